### sv/b64e_pkg.sv
// Shared types, constants and the character mapping of the Base64 encoder.
`timescale 1ns / 1ps

package b64e_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] PAD_CHAR = 8'h3d;

   localparam logic [1:0] LAST_SLOT = 2'd3;

   // One group of up to three bytes, ready to be turned into four characters.
   typedef struct packed {
      logic [23:0] bytes;
      logic [1:0]  nbytes;
      logic        last;
   } group_type;

   function automatic logic [7:0] sextet_char(input logic [5:0] s);
      logic [7:0] v;
      v = {2'b00, s};
      if (v < 8'd26) begin
         return 8'h41 + v;
      end else if (v < 8'd52) begin
         return 8'h61 + (v - 8'd26);
      end else if (v < 8'd62) begin
         return 8'h30 + (v - 8'd52);
      end else if (v == 8'd62) begin
         return 8'h2b;
      end else begin
         return 8'h2f;
      end
   endfunction

endpackage

### sv/b64e_if.sv
// Valid/ready channel interfaces for byte requests and character results.
`timescale 1ns / 1ps

interface b64e_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       final_byte;

   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64e_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       end_of_message;

   modport source (output valid, output out_char, output end_of_message, input ready);
   modport sink (input valid, input out_char, input end_of_message, output ready);
endinterface

### sv/b64e_front.sv
// Front end: gathers request bytes into groups and pushes each complete group and each group ended by a final byte.
`timescale 1ns / 1ps

module b64e_front (
   input  logic                clock,
   input  logic                reset,
   b64e_req_if.sink            req,
   input  logic                q_full,
   output logic                push,
   output b64e_pkg::group_type push_group
);

   logic [7:0] held0_ff, held0_in;
   logic [7:0] held1_ff, held1_in;
   logic [1:0] count_ff, count_in;
   logic       accept;

   assign req.ready = !q_full;
   assign accept    = req.valid && !q_full;

   always_comb begin
      held0_in   = held0_ff;
      held1_in   = held1_ff;
      count_in   = count_ff;
      push       = 1'b0;
      push_group = '0;
      if (count_ff[1]) begin
         push_group.bytes  = {held0_ff, held1_ff, req.data_byte};
         push_group.nbytes = 2'd3;
         push_group.last   = req.final_byte;
      end else if (count_ff[0]) begin
         push_group.bytes  = {held0_ff, req.data_byte, 8'h00};
         push_group.nbytes = 2'd2;
         push_group.last   = 1'b1;
      end else begin
         push_group.bytes  = {req.data_byte, 16'h0000};
         push_group.nbytes = 2'd1;
         push_group.last   = 1'b1;
      end
      if (accept) begin
         if (count_ff[1] || req.final_byte) begin
            push     = 1'b1;
            count_in = 2'd0;
            held0_in = 8'h00;
            held1_in = 8'h00;
         end else begin
            if (count_ff[0]) begin
               held1_in = req.data_byte;
            end else begin
               held0_in = req.data_byte;
            end
            count_in = count_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         held0_ff <= 8'h00;
         held1_ff <= 8'h00;
      end else begin
         count_ff <= count_in;
         held0_ff <= held0_in;
         held1_ff <= held1_in;
      end
   end

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("Front byte count reached three.");

   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req.final_byte) |=> (count_ff == 2'd0))
      else $error("Final byte did not clear the pending bytes.");
`endif

endmodule

### sv/b64e_queue.sv
// Short group queue between the front end and the character back end.
`timescale 1ns / 1ps

module b64e_queue #(
   parameter int DEPTH = b64e_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  b64e_pkg::group_type push_group,
   output logic                full,
   input  logic                pop,
   output logic                q_valid,
   output b64e_pkg::group_type q_group
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   b64e_pkg::group_type slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_group = slots_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_group;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("Group pushed into a full queue.");

   a_fill_to_full: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop && count_ff == CNT_W'(DEPTH - 1)) |=> full)
      else $error("Queue did not report full after its last slot was filled.");
`endif

endmodule

### sv/b64e_back.sv
// Back end: turns one queued group into four characters, one per cycle while the result channel is not stalled.
`timescale 1ns / 1ps

module b64e_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  b64e_pkg::group_type q_group,
   output logic                pop,
   b64e_rsp_if.source          rsp
);

   b64e_pkg::group_type group_ff, group_in;
   logic       busy_ff, busy_in;
   logic [1:0] slot_ff, slot_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_char_ff, rsp_char_in;
   logic       rsp_eom_ff, rsp_eom_in;
   logic       out_free;
   logic       emit;
   logic [5:0] sextet;
   logic [7:0] char_now;

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.out_char       = rsp_char_ff;
   assign rsp.end_of_message = rsp_eom_ff;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign emit     = busy_ff && out_free;
   assign pop      = q_valid && (!busy_ff || (emit && slot_ff == b64e_pkg::LAST_SLOT));

   always_comb begin
      case (slot_ff)
         2'd0:    sextet = group_ff.bytes[23:18];
         2'd1:    sextet = group_ff.bytes[17:12];
         2'd2:    sextet = group_ff.bytes[11:6];
         default: sextet = group_ff.bytes[5:0];
      endcase
      char_now = (slot_ff <= group_ff.nbytes) ? b64e_pkg::sextet_char(sextet)
                                              : b64e_pkg::PAD_CHAR;
   end

   always_comb begin
      group_in     = group_ff;
      busy_in      = busy_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_eom_in   = rsp_eom_ff;
      if (out_free) begin
         rsp_valid_in = emit;
      end
      if (emit) begin
         rsp_char_in = char_now;
         rsp_eom_in  = group_ff.last && (slot_ff == b64e_pkg::LAST_SLOT);
         slot_in     = slot_ff + 2'd1;
         if (slot_ff == b64e_pkg::LAST_SLOT) begin
            busy_in = 1'b0;
         end
      end
      if (pop) begin
         group_in = q_group;
         busy_in  = 1'b1;
         slot_in  = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         slot_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      group_ff    <= group_in;
      rsp_char_ff <= rsp_char_in;
      rsp_eom_ff  <= rsp_eom_in;
   end

`ifndef ASSERT_OFF
   a_stall_holds_slot: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !out_free) |=> ($stable(slot_ff) && busy_ff))
      else $error("Character slot moved while the output was stalled.");

   a_no_early_pad: assert property (@(posedge clock) disable iff (reset)
      (emit && (slot_ff == 2'd0 || slot_ff == 2'd1)) |-> (char_now != b64e_pkg::PAD_CHAR))
      else $error("Padding emitted in one of the first two character slots.");
`endif

endmodule

### sv/base64_stream_encoder.sv
// Top level of the streaming Base64 encoder with padding.
//
//   Channel   Direction  Payload                     Handshake
//   req_ch    in         data_byte[8], final_byte    valid / ready
//   rsp_ch    out        out_char[8], end_of_message valid / ready
//
// The back end emits one character per cycle while rsp_ch is not stalled,
// so a group of up to three bytes gives four characters, and a final partial
// group is padded out to four characters as well.
// A completed group passes a queue slot and group_ff to the output register.
// Synchronous reset empties the pending bytes, the group queue and the output.
// A stalled result channel holds the output register; the queue absorbs
// QUEUE_DEPTH groups before requests are refused.
`timescale 1ns / 1ps

module base64_stream_encoder #(
   parameter int QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   b64e_req_if.sink   req_ch,
   b64e_rsp_if.source rsp_ch
);

   b64e_pkg::group_type push_group;
   b64e_pkg::group_type q_group;
   logic                push;
   logic                full;
   logic                pop;
   logic                q_valid;

   b64e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .q_full     (full),
      .push       (push),
      .push_group (push_group)
   );

   b64e_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_group (push_group),
      .full       (full),
      .pop        (pop),
      .q_valid    (q_valid),
      .q_group    (q_group)
   );

   b64e_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_group (q_group),
      .pop     (pop),
      .rsp     (rsp_ch)
   );

endmodule

### bench/base64_stream_encoder_tb.sv
// Self-checking testbench of the streaming Base64 encoder with randomized flow control.
`timescale 1ns / 1ps

typedef struct {
   logic [7:0] ch;
   logic       eom;
} encoded_char_type;

class b64_char_scoreboard;
   logic [7:0]       held [2];
   logic [1:0]       held_count;
   encoded_char_type pending_chars [$];
   int               errors;
   string            alphabet;

   function new();
      held[0] = 8'h00;
      held[1] = 8'h00;
      held_count = 2'd0;
      errors = 0;
      alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
   endfunction

   task report(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      errors++;
   endtask

   function int pending();
      return pending_chars.size();
   endfunction

   function void encode_group(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                              int nbytes, logic last);
      logic [5:0]       s [4];
      encoded_char_type e;
      s[0] = b0[7:2];
      s[1] = {b0[1:0], b1[7:4]};
      s[2] = {b1[3:0], b2[7:6]};
      s[3] = b2[5:0];
      for (int k = 0; k < 4; k++) begin
         e.ch = (k <= nbytes) ? alphabet[s[k]] : b64e_pkg::PAD_CHAR;
         e.eom = last && (k == 3);
         pending_chars = {pending_chars, e};
      end
   endfunction

   function void note_request(logic [7:0] b, logic fin);
      if (held_count >= 2'd2) begin
         encode_group(held[0], held[1], b, 3, fin);
         held_count = 2'd0;
         held[0] = 8'h00;
         held[1] = 8'h00;
      end else if (fin) begin
         if (held_count == 2'd1) begin
            encode_group(held[0], b, 8'h00, 2, 1'b1);
         end else begin
            encode_group(b, 8'h00, 8'h00, 1, 1'b1);
         end
         held_count = 2'd0;
         held[0] = 8'h00;
         held[1] = 8'h00;
      end else begin
         held[held_count[0]] = b;
         held_count = held_count + 2'd1;
      end
   endfunction

   task check_result(logic [7:0] ch, logic eom);
      encoded_char_type e;
      if (pending_chars.size() == 0) begin
         report($sformatf("unexpected character %h eom %b", ch, eom));
         return;
      end
      e = pending_chars.pop_front();
      if (ch !== e.ch) begin
         report($sformatf("character %h, expected %h", ch, e.ch));
      end
      if (eom !== e.eom) begin
         report($sformatf("end_of_message %b, expected %b on character %h", eom, e.eom, e.ch));
      end
   endtask
endclass

module base64_stream_encoder_tb;

   logic clock = 1'b0;
   logic reset = 1'b1;

   b64e_req_if req ();
   b64e_rsp_if rsp ();

   b64_char_scoreboard sb = new();

   int burst_left = 0;
   int requests_sent = 0;
   int stall_mode = 0;
   int mode_left = 0;
   int stall_left = 0;

   base64_stream_encoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req.sink),
      .rsp_ch (rsp.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // Called and returning at a falling edge; valid stays high across back-to-back requests.
   task automatic send_request(input logic [7:0] b, input logic fin);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 16);
         if (gap > 0) begin
            req.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req.valid = 1'b1;
      req.data_byte = b;
      req.final_byte = fin;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sb.note_request(b, fin);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic send_message(input logic [7:0] msg [$]);
      for (int i = 0; i < msg.size(); i++) begin
         send_request(msg[i], i == msg.size() - 1);
      end
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hff;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         rsp.ready = 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 120);
         end
         mode_left--;
         case (stall_mode)
            0: rsp.ready = 1'b1;
            1: rsp.ready = 1'($urandom_range(0, 1));
            default: begin
               if (stall_left > 0) begin
                  rsp.ready = 1'b0;
                  stall_left--;
               end else begin
                  rsp.ready = 1'b1;
                  if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 8);
               end
            end
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         sb.check_result(rsp.out_char, rsp.end_of_message);
      end
   end

   initial begin
      logic [7:0] msg [$];
      int len;
      req.valid = 1'b0;
      req.data_byte = 8'h00;
      req.final_byte = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed messages cover single and double padding, full groups, and the
      // characters at both ends of the alphabet.
      msg = '{8'h00};
      send_message(msg);
      msg = '{8'hff, 8'hff};
      send_message(msg);
      msg = '{8'hfb, 8'hef, 8'hbe};
      send_message(msg);
      msg = '{8'hff, 8'hff, 8'hff, 8'h00};
      send_message(msg);
      msg = '{8'h00, 8'h10, 8'h83, 8'h10, 8'h51, 8'h87};
      send_message(msg);
      msg = '{8'h55, 8'haa, 8'h01, 8'h80, 8'h7f};
      send_message(msg);

      while (requests_sent < 360) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 9);
         msg.delete();
         for (int i = 0; i < len; i++) msg = {msg, pick_byte()};
         send_message(msg);
      end
      req.valid = 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
